/* hdl/rjd_pkg.sv */
// ----------------------------------------------------------------------------
// rjd_pkg: shared types and constants of the run and jibe detector
// Field widths, fixed-point constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package rjd_pkg;

    // log index width kept for the last jibe sample
    localparam int INDEX_BITS = 16;

    // fixed-point mean: 27-bit heading plus 16 fraction bits, one guard bit
    localparam int FRAC_BITS = 16;
    localparam int HEAD_W    = 27;
    localparam int ACC_W     = 44;
    localparam int N_W       = 14;
    localparam int REM_W     = N_W + 1;
    localparam int CNT_W     = 6;

    // last bit position of the serial divider
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

    localparam logic signed [16:0] TURN         = 17'sd36000;
    localparam logic signed [17:0] UNWRAP_JUMP  = 18'sd30000;
    localparam logic signed [10:0] OFFSET_LIMIT = 11'sd1000;
    localparam logic [15:0]        COUNT_MAX    = 16'hffff;

    // configuration register indexes
    localparam logic [2:0] CFG_FIX_RATE      = 3'd0;
    localparam logic [2:0] CFG_RUN_DELAY     = 3'd1;
    localparam logic [2:0] CFG_MEAN_SECONDS  = 3'd2;
    localparam logic [2:0] CFG_MOVING_MIN    = 3'd3;
    localparam logic [2:0] CFG_STANDSTILL    = 3'd4;
    localparam logic [2:0] CFG_STRAIGHT_MAX  = 3'd5;
    localparam logic [2:0] CFG_JIBE_MIN      = 3'd6;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIFF,
        S_ABS,
        S_DIV,
        S_UPD,
        S_DEV,
        S_EVAL
    } t_state;

endpackage

/* hdl/run_and_jibe_detector.sv */
// ----------------------------------------------------------------------------
// run_and_jibe_detector: run and jibe detection on a stream of GPS samples
// Unwraps the heading, keeps an exponential mean heading through a bit-serial
// divider and tracks speed and course state to count runs and jibes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries heading, speed and log
//   index of one sample; a transfer happens when valid is high and stall low.
//   Output channel (o_out_valid / i_out_stall) returns one result per sample.
//   Configuration registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_data, one register per cycle, while no sample is in flight.
// Operation:
//   The mean update divides by mean_seconds times the fix rate with a
//   restoring divider that retires one quotient bit per cycle over 44 bits.
//   Each sample passes the prep, difference, absolute, divide, update,
//   deviation and final steps; its result is registered in the final step
//   and the next sample is taken only after that, in the following cycle.
// Reset:
//   A synchronous low i_rst_n returns all configuration registers to their
//   defaults, clears the heading, mean and counter state and sets the last
//   jibe index to -1. The output register is a stage of its own: while the
//   receiver stalls, the held result stays and the next sample is still
//   taken; only the final step of that sample waits for the register to free.
// ----------------------------------------------------------------------------
module run_and_jibe_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [15:0]                         i_heading_in,
    input  logic [15:0]                         i_speed_in,
    input  logic [15:0]                         i_sample_index,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rjd_pkg::HEAD_W-1:0]   o_unwrapped_heading,
    output logic signed [rjd_pkg::HEAD_W-1:0]   o_mean_heading_out,
    output logic [15:0]                         o_run_number,
    output logic                                o_run_started,
    output logic [15:0]                         o_jibe_number,
    output logic                                o_jibe_now,
    output logic signed [rjd_pkg::INDEX_BITS:0] o_last_jibe_sample
);

    // configuration registers
    logic [5:0]  r_fix_rate;
    logic [5:0]  r_run_delay;
    logic [7:0]  r_mean_seconds;
    logic [15:0] r_moving_min;
    logic [15:0] r_standstill_max;
    logic [15:0] r_straight_max;
    logic [15:0] r_jibe_min;

    // sequencer
    rjd_pkg::t_state r_state, n_state;
    logic            in_xfer;
    logic            out_free;
    logic            eval_done;

    // sample state
    logic [15:0]                       r_prev_heading;
    logic signed [10:0]                r_turn_offset;
    logic signed [rjd_pkg::ACC_W-1:0]  r_acc;
    logic                              r_was_fast;
    logic                              r_stop_after_fast;
    logic                              r_straight;
    logic [15:0]                       r_delay_count;
    logic [15:0]                       r_run_count;
    logic [15:0]                       r_jibe_count;
    logic signed [rjd_pkg::INDEX_BITS:0] r_last_jibe;

    // per-sample working registers
    logic [15:0]                       r_hin;
    logic [15:0]                       r_speed;
    logic [15:0]                       r_index;
    logic signed [rjd_pkg::HEAD_W-1:0] r_heading;
    logic [rjd_pkg::N_W-1:0]           r_n;
    logic signed [rjd_pkg::ACC_W-1:0]  r_diff;
    logic                              r_neg;
    logic [rjd_pkg::ACC_W-1:0]         r_div;
    logic [rjd_pkg::REM_W-1:0]         r_rem;
    logic [rjd_pkg::CNT_W-1:0]         r_count;

    // output register
    logic                              r_out_valid;
    logic signed [rjd_pkg::HEAD_W-1:0] r_out_heading;
    logic signed [rjd_pkg::HEAD_W-1:0] r_out_mean;
    logic [15:0]                       r_out_runs;
    logic                              r_out_started;
    logic [15:0]                       r_out_jibes;
    logic                              r_out_jibe_now;
    logic signed [rjd_pkg::INDEX_BITS:0] r_out_last_jibe;

    // unwrap step on the incoming heading
    logic signed [17:0] head_step;
    assign head_step = $signed({2'b00, i_heading_in}) - $signed({2'b00, r_prev_heading});

    // heading scaled to the mean's fixed-point format
    logic signed [rjd_pkg::ACC_W-1:0] hfix;
    assign hfix = {r_heading[rjd_pkg::HEAD_W-1], r_heading, {rjd_pkg::FRAC_BITS{1'b0}}};

    // mean time constant in samples; r_n takes one in its place when it is zero
    logic [rjd_pkg::N_W-1:0] n_prod;
    assign n_prod = rjd_pkg::N_W'(r_mean_seconds) * rjd_pkg::N_W'(r_fix_rate);

    // one restoring divider step
    logic [rjd_pkg::REM_W-1:0] rem_shift;
    logic                      rem_ge;
    assign rem_shift = {r_rem[rjd_pkg::REM_W-2:0], r_div[rjd_pkg::ACC_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_n};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rjd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        in_xfer    = 1'b0;
        eval_done  = 1'b0;
        unique case (r_state)
            rjd_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                in_xfer    = i_in_valid;
                if (i_in_valid) n_state = rjd_pkg::S_PREP;
            end
            rjd_pkg::S_PREP: n_state = rjd_pkg::S_DIFF;
            rjd_pkg::S_DIFF: n_state = rjd_pkg::S_ABS;
            rjd_pkg::S_ABS:  n_state = rjd_pkg::S_DIV;
            rjd_pkg::S_DIV: begin
                if (r_count == rjd_pkg::DIV_LAST) n_state = rjd_pkg::S_UPD;
            end
            rjd_pkg::S_UPD:  n_state = rjd_pkg::S_DEV;
            rjd_pkg::S_DEV:  n_state = rjd_pkg::S_EVAL;
            rjd_pkg::S_EVAL: begin
                if (out_free) begin
                    eval_done = 1'b1;
                    n_state   = rjd_pkg::S_IDLE;
                end
            end
            default: n_state = rjd_pkg::S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_rate       <= 6'd10;
            r_run_delay      <= 6'd2;
            r_mean_seconds   <= 8'd15;
            r_moving_min     <= 16'd750;
            r_standstill_max <= 16'd200;
            r_straight_max   <= 16'd1000;
            r_jibe_min       <= 16'd5000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rjd_pkg::CFG_FIX_RATE:     r_fix_rate       <= i_cfg_data[5:0];
                rjd_pkg::CFG_RUN_DELAY:    r_run_delay      <= i_cfg_data[5:0];
                rjd_pkg::CFG_MEAN_SECONDS: r_mean_seconds   <= i_cfg_data[7:0];
                rjd_pkg::CFG_MOVING_MIN:   r_moving_min     <= i_cfg_data;
                rjd_pkg::CFG_STANDSTILL:   r_standstill_max <= i_cfg_data;
                rjd_pkg::CFG_STRAIGHT_MAX: r_straight_max   <= i_cfg_data;
                rjd_pkg::CFG_JIBE_MIN:     r_jibe_min       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // course and counter decisions of the final step
    logic        fast, stop, restart;
    logic        is_straight, is_jibe;
    logic        n_was_fast, n_stop_after_fast, n_straight;
    logic [15:0] n_delay_count, n_run_count, n_jibe_count;
    logic        n_started;
    logic [15:0] run_target;
    logic [rjd_pkg::ACC_W-1:0] straight_lim, jibe_lim;

    assign straight_lim = {12'd0, r_straight_max, {rjd_pkg::FRAC_BITS{1'b0}}};
    assign jibe_lim     = {12'd0, r_jibe_min, {rjd_pkg::FRAC_BITS{1'b0}}};
    assign run_target   = 16'(r_run_delay) * 16'(r_fix_rate);

    always_comb begin
        fast              = r_speed > r_moving_min;
        stop              = r_speed < r_standstill_max;
        n_was_fast        = r_was_fast | fast;
        n_stop_after_fast = r_stop_after_fast | (stop & n_was_fast);
        n_straight        = r_straight;
        n_delay_count     = r_delay_count;
        n_jibe_count      = r_jibe_count;
        n_run_count       = r_run_count;
        n_started         = 1'b0;
        restart           = n_stop_after_fast & fast;
        // restart from standstill
        if (restart) begin
            n_stop_after_fast = 1'b0;
            n_was_fast        = 1'b0;
            n_straight        = 1'b0;
            n_delay_count     = (r_run_delay != 6'd0)
                              ? 16'(r_run_delay - 6'd1) * 16'(r_fix_rate) : 16'd0;
        end
        // r_div holds the deviation magnitude here
        is_straight = (r_div < straight_lim) & fast;
        if (is_straight) n_straight = 1'b1;
        is_jibe = (r_div > jibe_lim) & n_straight;
        if (is_jibe) begin
            n_straight    = 1'b0;
            n_delay_count = 16'd0;
            if (r_jibe_count != rjd_pkg::COUNT_MAX) n_jibe_count = r_jibe_count + 16'd1;
        end
        // delay count and run start
        if (n_delay_count != rjd_pkg::COUNT_MAX) n_delay_count = n_delay_count + 16'd1;
        if (n_delay_count == run_target) begin
            n_started = 1'b1;
            if (r_run_count != rjd_pkg::COUNT_MAX) n_run_count = r_run_count + 16'd1;
        end
    end

    // persistent sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_heading    <= 16'd0;
            r_turn_offset     <= 11'sd0;
            r_acc             <= '0;
            r_was_fast        <= 1'b0;
            r_stop_after_fast <= 1'b0;
            r_straight        <= 1'b0;
            r_delay_count     <= 16'd0;
            r_run_count       <= 16'd0;
            r_jibe_count      <= 16'd0;
            r_last_jibe       <= '1;
        end else begin
            // turn counting on large heading jumps
            if (in_xfer) begin
                r_prev_heading <= i_heading_in;
                if (head_step > rjd_pkg::UNWRAP_JUMP && r_turn_offset > -rjd_pkg::OFFSET_LIMIT)
                    r_turn_offset <= r_turn_offset - 11'sd1;
                else if (head_step < -rjd_pkg::UNWRAP_JUMP
                         && r_turn_offset < rjd_pkg::OFFSET_LIMIT)
                    r_turn_offset <= r_turn_offset + 11'sd1;
            end
            // apply the truncated mean step
            if (r_state == rjd_pkg::S_UPD) begin
                r_acc <= r_neg ? r_acc - $signed(r_div) : r_acc + $signed(r_div);
            end
            if (eval_done) begin
                r_was_fast        <= n_was_fast;
                r_stop_after_fast <= n_stop_after_fast;
                r_straight        <= n_straight;
                r_delay_count     <= n_delay_count;
                r_run_count       <= n_run_count;
                r_jibe_count      <= n_jibe_count;
                if (is_jibe)
                    r_last_jibe <= $signed({1'b0, rjd_pkg::INDEX_BITS'(r_index)});
            end
        end
    end

    // working datapath: heading, difference, serial divider, deviation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (r_state)
                rjd_pkg::S_IDLE: begin
                    r_hin   <= i_heading_in;
                    r_speed <= i_speed_in;
                    r_index <= i_sample_index;
                end
                rjd_pkg::S_PREP: begin
                    r_heading <= r_turn_offset * rjd_pkg::TURN + $signed({1'b0, r_hin});
                    r_n       <= (n_prod == '0) ? rjd_pkg::N_W'(1) : n_prod;
                end
                rjd_pkg::S_DIFF: begin
                    r_diff <= hfix - r_acc;
                end
                rjd_pkg::S_ABS: begin
                    r_neg   <= r_diff[rjd_pkg::ACC_W-1];
                    r_div   <= r_diff[rjd_pkg::ACC_W-1] ? unsigned'(-r_diff) : unsigned'(r_diff);
                    r_rem   <= '0;
                    r_count <= '0;
                end
                rjd_pkg::S_DIV: begin
                    // one quotient bit per cycle, quotient shifts in behind the dividend
                    r_rem   <= rem_ge ? rem_shift - {1'b0, r_n} : rem_shift;
                    r_div   <= {r_div[rjd_pkg::ACC_W-2:0], rem_ge};
                    r_count <= r_count + rjd_pkg::CNT_W'(1);
                end
                rjd_pkg::S_UPD: begin
                    r_diff <= r_diff;
                end
                rjd_pkg::S_DEV: begin
                    // deviation magnitude of the updated mean
                    r_div <= (r_acc < hfix) ? unsigned'(hfix - r_acc) : unsigned'(r_acc - hfix);
                end
                default: ;
            endcase
        end
    end

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_done) begin
            r_out_heading   <= r_heading;
            r_out_mean      <= rjd_pkg::HEAD_W'(r_acc >>> rjd_pkg::FRAC_BITS);
            r_out_runs      <= n_run_count;
            r_out_started   <= n_started;
            r_out_jibes     <= n_jibe_count;
            r_out_jibe_now  <= is_jibe;
            r_out_last_jibe <= is_jibe ? $signed({1'b0, rjd_pkg::INDEX_BITS'(r_index)})
                                       : r_last_jibe;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_unwrapped_heading = r_out_heading;
    assign o_mean_heading_out  = r_out_mean;
    assign o_run_number        = r_out_runs;
    assign o_run_started       = r_out_started;
    assign o_jibe_number       = r_out_jibes;
    assign o_jibe_now          = r_out_jibe_now;
    assign o_last_jibe_sample  = r_out_last_jibe;

`ifndef SYNTHESIS
    // turn offset never leaves its saturation range
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_turn_offset <= rjd_pkg::OFFSET_LIMIT && r_turn_offset >= -rjd_pkg::OFFSET_LIMIT)
        else $error("turn offset out of range");

    // a new result only appears out of the final step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == rjd_pkg::S_EVAL))
        else $error("result without final step");

    // divider leaves after exactly one pass over the dividend
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rjd_pkg::S_DIV && r_count == rjd_pkg::DIV_LAST)
        |=> r_state == rjd_pkg::S_UPD)
        else $error("divider pass length wrong");

    // remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rjd_pkg::S_DIV |-> r_rem < {1'b0, r_n})
        else $error("divider remainder out of range");

    // a reported jibe always carries a valid index
    a_jibe_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jibe_now) |-> (!o_last_jibe_sample[rjd_pkg::INDEX_BITS]
                                         && o_jibe_number != 16'd0))
        else $error("jibe reported without index");
`endif

endmodule

/* bench/rjd_track_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjd_track_checker: result checker for the run and jibe detector
// Watches register writes and both channels, runs its own copy of the heading,
// mean and run/jibe state for every sample transfer and compares each result
// transfer field by field against the oldest predicted track result.
// ----------------------------------------------------------------------------
module rjd_track_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_index,
    input  logic [15:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [15:0]                         i_heading_in,
    input  logic [15:0]                         i_speed_in,
    input  logic [15:0]                         i_sample_index,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [rjd_pkg::HEAD_W-1:0]   i_unwrapped_heading,
    input  logic signed [rjd_pkg::HEAD_W-1:0]   i_mean_heading_out,
    input  logic [15:0]                         i_run_number,
    input  logic                                i_run_started,
    input  logic [15:0]                         i_jibe_number,
    input  logic                                i_jibe_now,
    input  logic signed [rjd_pkg::INDEX_BITS:0] i_last_jibe_sample,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_run_starts,
    output int                                  o_jibes_seen
);

    localparam longint FRAC_ONE = longint'(1) << rjd_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [rjd_pkg::HEAD_W-1:0]   unwrapped;
        logic signed [rjd_pkg::HEAD_W-1:0]   mean;
        logic [15:0]                         run_number;
        logic                                run_started;
        logic [15:0]                         jibe_number;
        logic                                jibe_now;
        logic signed [rjd_pkg::INDEX_BITS:0] last_jibe;
    } t_track_result;

    t_track_result awaited_tracks[$];
    t_track_result oldest;

    // local copy of the configuration registers
    int rate_reg;
    int run_delay_reg;
    int mean_seconds_reg;
    int moving_min_reg;
    int standstill_max_reg;
    int straight_max_reg;
    int jibe_min_reg;

    // local copy of the tracking state
    logic [15:0] last_heading;
    int          turn_count;
    longint      mean_fixed;
    bit          seen_fast;
    bit          halted_after_fast;
    bit          on_straight;
    int          delay_ticks;
    int          runs;
    int          jibes;
    longint      last_jibe_index;

    // advance the track by one sample and return the result it produces
    function automatic t_track_result advance_track(input logic [15:0] hin,
                                                    input logic [15:0] spd,
                                                    input logic [15:0] idx);
        t_track_result r;
        int     step;
        int     target;
        longint heading;
        longint heading_fixed;
        longint divisor;
        longint dev;
        longint floor_mean;
        bit     fast;
        bit     halted;
        bit     jibed;
        bit     started;

        // unwrap across the 0/360 seam, offset saturating
        step = int'(hin) - int'(last_heading);
        if (step > int'(rjd_pkg::UNWRAP_JUMP) && turn_count > -int'(rjd_pkg::OFFSET_LIMIT))
            turn_count--;
        if (step < -int'(rjd_pkg::UNWRAP_JUMP) && turn_count < int'(rjd_pkg::OFFSET_LIMIT))
            turn_count++;
        last_heading = hin;
        heading = longint'(hin) + longint'(turn_count) * longint'(rjd_pkg::TURN);

        // exponential mean, step truncated toward zero
        divisor = longint'(mean_seconds_reg) * longint'(rate_reg);
        if (divisor == 0)
            divisor = 1;
        heading_fixed = heading * FRAC_ONE;
        mean_fixed = mean_fixed + (heading_fixed - mean_fixed) / divisor;

        // moving / stopped / restart
        fast   = int'(spd) > moving_min_reg;
        halted = int'(spd) < standstill_max_reg;
        if (fast)
            seen_fast = 1'b1;
        if (halted && seen_fast)
            halted_after_fast = 1'b1;
        if (halted_after_fast && fast) begin
            halted_after_fast = 1'b0;
            seen_fast = 1'b0;
            on_straight = 1'b0;
            delay_ticks = run_delay_reg > 0 ? (run_delay_reg - 1) * rate_reg : 0;
        end

        // straight course and jibe
        jibed = 1'b0;
        dev = mean_fixed - heading_fixed;
        if (dev < 0)
            dev = -dev;
        if (dev < longint'(straight_max_reg) * FRAC_ONE && fast)
            on_straight = 1'b1;
        if (dev > longint'(jibe_min_reg) * FRAC_ONE && on_straight) begin
            on_straight = 1'b0;
            delay_ticks = 0;
            if (jibes < int'(rjd_pkg::COUNT_MAX))
                jibes++;
            last_jibe_index = longint'(idx);
            jibed = 1'b1;
        end

        // run start once the delay reaches its target
        started = 1'b0;
        if (delay_ticks < int'(rjd_pkg::COUNT_MAX))
            delay_ticks++;
        target = run_delay_reg * rate_reg;
        if (delay_ticks == target) begin
            if (runs < int'(rjd_pkg::COUNT_MAX))
                runs++;
            started = 1'b1;
        end

        floor_mean    = mean_fixed >>> rjd_pkg::FRAC_BITS;
        r.unwrapped   = heading[rjd_pkg::HEAD_W-1:0];
        r.mean        = floor_mean[rjd_pkg::HEAD_W-1:0];
        r.run_number  = runs[15:0];
        r.run_started = started;
        r.jibe_number = jibes[15:0];
        r.jibe_now    = jibed;
        r.last_jibe   = last_jibe_index[rjd_pkg::INDEX_BITS:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            o_fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_reg           = 10;
            run_delay_reg      = 2;
            mean_seconds_reg   = 15;
            moving_min_reg     = 750;
            standstill_max_reg = 200;
            straight_max_reg   = 1000;
            jibe_min_reg       = 5000;
            last_heading       = '0;
            turn_count         = 0;
            mean_fixed         = 0;
            seen_fast          = 1'b0;
            halted_after_fast  = 1'b0;
            on_straight        = 1'b0;
            delay_ticks        = 0;
            runs               = 0;
            jibes              = 0;
            last_jibe_index    = -1;
            awaited_tracks.delete();
        end else begin
            // result transfer against the oldest pending sample
            if (i_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (awaited_tracks.size() == 0) begin
                    o_fail_count++;
                    $error("result transfer with no sample pending");
                end else begin
                    oldest = awaited_tracks.pop_front();
                    check_field("unwrapped_heading", oldest.unwrapped, i_unwrapped_heading);
                    check_field("mean_heading_out", oldest.mean, i_mean_heading_out);
                    check_field("run_number", oldest.run_number, i_run_number);
                    check_field("run_started", oldest.run_started, i_run_started);
                    check_field("jibe_number", oldest.jibe_number, i_jibe_number);
                    check_field("jibe_now", oldest.jibe_now, i_jibe_now);
                    check_field("last_jibe_sample", oldest.last_jibe, i_last_jibe_sample);
                    o_checked++;
                    o_run_starts += int'(oldest.run_started);
                    o_jibes_seen += int'(oldest.jibe_now);
                end
            end

            // register write
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rjd_pkg::CFG_FIX_RATE:     rate_reg           = int'(i_cfg_data[5:0]);
                    rjd_pkg::CFG_RUN_DELAY:    run_delay_reg      = int'(i_cfg_data[5:0]);
                    rjd_pkg::CFG_MEAN_SECONDS: mean_seconds_reg   = int'(i_cfg_data[7:0]);
                    rjd_pkg::CFG_MOVING_MIN:   moving_min_reg     = int'(i_cfg_data);
                    rjd_pkg::CFG_STANDSTILL:   standstill_max_reg = int'(i_cfg_data);
                    rjd_pkg::CFG_STRAIGHT_MAX: straight_max_reg   = int'(i_cfg_data);
                    rjd_pkg::CFG_JIBE_MIN:     jibe_min_reg       = int'(i_cfg_data);
                    default: ;
                endcase
            end

            // sample transfer
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                awaited_tracks.push_back(advance_track(i_heading_in, i_speed_in,
                                                       i_sample_index));
        end
        o_pending = awaited_tracks.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level of the run and jibe detector bench
// Drives directed GPS samples, sailing-like random legs under a range of
// register settings and a turn-offset sweep in both directions, with random
// gaps and receiver stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT      = 15_000_000;
    localparam int TURNS_DOWN = 20;
    localparam int TURNS_UP   = 30;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle;
    typedef enum int {LEG_CRUISE, LEG_STOP, LEG_TURN, LEG_NOISE} t_leg;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_cfg_we       = 1'b0;
    logic [2:0]                          i_cfg_index    = '0;
    logic [15:0]                         i_cfg_data     = '0;
    logic                                i_in_valid     = 1'b0;
    logic                                o_in_stall;
    logic [15:0]                         i_heading_in   = '0;
    logic [15:0]                         i_speed_in     = '0;
    logic [15:0]                         i_sample_index = '0;
    logic                                o_out_valid;
    logic                                i_out_stall    = 1'b0;
    logic signed [rjd_pkg::HEAD_W-1:0]   o_unwrapped_heading;
    logic signed [rjd_pkg::HEAD_W-1:0]   o_mean_heading_out;
    logic [15:0]                         o_run_number;
    logic                                o_run_started;
    logic [15:0]                         o_jibe_number;
    logic                                o_jibe_now;
    logic signed [rjd_pkg::INDEX_BITS:0] o_last_jibe_sample;

    int    fail_count;
    int    pending;
    int    checked;
    int    run_starts;
    int    jibes_seen;
    t_idle idle_mode      = IDLE_NONE;
    int    settings_used  = 0;
    int    log_index      = 0;
    int    course         = 0;
    int    cur_moving     = 750;
    int    cur_standstill = 200;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    run_and_jibe_detector dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_heading_in        (i_heading_in),
        .i_speed_in          (i_speed_in),
        .i_sample_index      (i_sample_index),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_unwrapped_heading (o_unwrapped_heading),
        .o_mean_heading_out  (o_mean_heading_out),
        .o_run_number        (o_run_number),
        .o_run_started       (o_run_started),
        .o_jibe_number       (o_jibe_number),
        .o_jibe_now          (o_jibe_now),
        .o_last_jibe_sample  (o_last_jibe_sample)
    );

    rjd_track_checker track_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_heading_in        (i_heading_in),
        .i_speed_in          (i_speed_in),
        .i_sample_index      (i_sample_index),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_unwrapped_heading (o_unwrapped_heading),
        .i_mean_heading_out  (o_mean_heading_out),
        .i_run_number        (o_run_number),
        .i_run_started       (o_run_started),
        .i_jibe_number       (o_jibe_number),
        .i_jibe_now          (o_jibe_now),
        .i_last_jibe_sample  (o_last_jibe_sample),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_checked           (checked),
        .o_run_starts        (run_starts),
        .o_jibes_seen        (jibes_seen)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (idle_mode == IDLE_NONE)
            return 0;
        if (idle_mode == IDLE_LIGHT) begin
            if (roll < 60)
                return 0;
            if (roll < 95)
                return $urandom_range(4, 1);
            return $urandom_range(150, 20);
        end
        if (roll < 25)
            return 0;
        if (roll < 80)
            return $urandom_range(8, 1);
        return $urandom_range(150, 20);
    endfunction

    // speed clearly above the moving threshold
    function automatic int fast_speed();
        int lo;
        int hi;
        lo = cur_moving < 65535 ? cur_moving + 1 : 65535;
        hi = lo + 2000 > 65535 ? 65535 : lo + 2000;
        return $urandom_range(hi, lo);
    endfunction

    // receiver stall bursts
    always @(posedge i_clk) begin : out_stall_gen
        int n;
        int stall_left;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            n = pick_gap();
            i_out_stall <= n > 0;
            stall_left = n > 0 ? n - 1 : 0;
        end
    end

    // watchdog
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("run_and_jibe_detector verification failed");
        $finish;
    end

    // one sample transfer, then an optional gap
    task automatic send_sample(input int heading, input int speed);
        int gap;
        i_heading_in   <= 16'(heading);
        i_speed_in     <= 16'(speed);
        i_sample_index <= 16'(log_index);
        i_in_valid     <= 1'b1;
        log_index = (log_index + 1) & 16'hffff;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every predicted result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // write all seven registers back to back
    task automatic apply_config(input int rate, input int delay, input int mean_s,
                                input int moving, input int standstill,
                                input int straight, input int jibe);
        logic [2:0] regs [7];
        int         vals [7];
        regs = '{rjd_pkg::CFG_FIX_RATE, rjd_pkg::CFG_RUN_DELAY, rjd_pkg::CFG_MEAN_SECONDS,
                 rjd_pkg::CFG_MOVING_MIN, rjd_pkg::CFG_STANDSTILL,
                 rjd_pkg::CFG_STRAIGHT_MAX, rjd_pkg::CFG_JIBE_MIN};
        vals = '{rate, delay, mean_s, moving, standstill, straight, jibe};
        for (int r = 0; r < 7; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= 16'(vals[r]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_moving = moving;
        cur_standstill = standstill;
        settings_used++;
    endtask

    // random sailing legs under one register setting
    task automatic sail_phase(input int rate, input int delay, input int mean_s,
                              input int moving, input int standstill,
                              input int straight, input int jibe,
                              input int count, input t_idle mode);
        t_leg leg;
        int   leg_left;
        int   roll;
        int   spd;
        apply_config(rate, delay, mean_s, moving, standstill, straight, jibe);
        idle_mode = mode;
        leg = LEG_CRUISE;
        leg_left = 0;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2)
                wait_drained();
            if (leg_left == 0) begin
                roll = $urandom_range(99);
                if (roll < 50) begin
                    leg = LEG_CRUISE;
                    leg_left = $urandom_range(40, 5);
                end else if (roll < 70) begin
                    leg = LEG_STOP;
                    leg_left = $urandom_range(10, 2);
                end else if (roll < 85) begin
                    leg = LEG_TURN;
                    leg_left = $urandom_range(2, 1);
                end else begin
                    leg = LEG_NOISE;
                    leg_left = $urandom_range(5, 1);
                end
            end
            leg_left--;
            case (leg)
                LEG_CRUISE: begin
                    course += int'($urandom_range(300)) - 150;
                    spd = fast_speed();
                end
                LEG_STOP: begin
                    course += int'($urandom_range(600)) - 300;
                    spd = cur_standstill == 0 ? 0 : $urandom_range(cur_standstill - 1, 0);
                end
                LEG_TURN: begin
                    course += ($urandom_range(1) ? 1 : -1) * int'($urandom_range(18000, 6000));
                    spd = fast_speed();
                end
                default: begin
                    course = $urandom_range(35999);
                    spd = $urandom_range(65535);
                end
            endcase
            course = ((course % 36000) + 36000) % 36000;
            send_sample(course, spd);
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: wraps both ways, restart, straight course, jibe, extremes
        apply_config(10, 2, 15, 750, 200, 1000, 5000);
        idle_mode = IDLE_NONE;
        log_index = 65534;
        send_sample(0, 0);
        send_sample(35999, 65535);
        send_sample(0, 1000);
        send_sample(35999, 0);
        send_sample(35999, 800);
        for (int k = 0; k < 5; k++)
            send_sample(35990 + 2 * k, 800);
        send_sample(17999, 800);
        send_sample(32768, 1);
        send_sample(1, 65534);
        // a jump of exactly the threshold does not unwrap, one more does
        send_sample(30001, 800);
        send_sample(0, 800);
        wait_drained();

        // restart with a one-second delay starts a run at once
        apply_config(1, 1, 1, 750, 200, 1000, 5000);
        send_sample(100, 0);
        send_sample(100, 1000);
        send_sample(100, 0);
        send_sample(100, 1000);
        wait_drained();

        // random legs over several settings, extremes included
        sail_phase(10, 2, 15, 750, 200, 1000, 5000, 100, IDLE_LIGHT);
        sail_phase(1, 2, 2, 500, 300, 2000, 3000, 100, IDLE_HEAVY);
        sail_phase(1, 1, 1, 0, 0, 0, 0, 80, IDLE_NONE);
        sail_phase(0, 0, 0, 1000, 500, 800, 3000, 80, IDLE_LIGHT);
        sail_phase(50, 60, 255, 65535, 65535, 36000, 36000, 80, IDLE_LIGHT);
        sail_phase(3, 0, 40, 900, 150, 1200, 4000, 80, IDLE_HEAVY);
        repeat (3)
            sail_phase($urandom_range(50, 1), $urandom_range(3, 1), $urandom_range(20, 1),
                       $urandom_range(1500, 300), $urandom_range(250, 0),
                       $urandom_range(3000, 200), $urandom_range(9000, 2000),
                       80, IDLE_LIGHT);
        sail_phase(5, 1, 3, 750, 200, 1500, 4000, 80, IDLE_NONE);

        // turn offset walked downward, then back up past zero
        idle_mode = IDLE_NONE;
        send_sample(0, $urandom_range(65535));
        for (int t = 0; t < TURNS_DOWN; t++) begin
            send_sample(35999, $urandom_range(65535));
            send_sample(18000, $urandom_range(65535));
            send_sample(0, $urandom_range(65535));
        end
        for (int t = 0; t < TURNS_UP; t++) begin
            send_sample(18000, $urandom_range(65535));
            send_sample(35999, $urandom_range(65535));
            send_sample(0, $urandom_range(65535));
        end
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("checked %0d results under %0d register settings", checked, settings_used);
        $display("turn offset swept both ways, predicted %0d run starts and %0d jibes",
                 run_starts, jibes_seen);
        if (fail_count == 0 && pending == 0)
            $display("run_and_jibe_detector verification clean");
        else
            $display("run_and_jibe_detector verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rjd_pkg.sv
hdl/run_and_jibe_detector.sv
bench/rjd_track_checker.sv
bench/testbench.sv
